/* rtl/core/morse_key_decoder_macros.svh */
// Assertion macros for the morse key decoder checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef MORSE_KEY_DECODER_MACROS_SVH
`define MORSE_KEY_DECODER_MACROS_SVH

// Same-cycle implication, switched off while reset is held
`define MKD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("morse key decoder: same-cycle check failed");

// Next-cycle implication, switched off while reset is held
`define MKD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("morse key decoder: next-cycle check failed");

// Condition that must hold on the cycle after a reset edge
`define MKD_ASSERT_RESET(lbl, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("morse key decoder: reset check failed");

`endif

/* rtl/core/mkd_pkg.sv */
// Package for the morse key decoder: widths, character codes, record types
// and the letter code table. No dependencies.
package mkd_pkg;

  // Timer width and the width used to compare timers with 16-bit registers
  localparam int TIMER_BITS = 16;
  localparam int REG_BITS   = 16;
  localparam int CMP_BITS   = (TIMER_BITS > REG_BITS) ? TIMER_BITS : REG_BITS;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  // Symbol count saturates here once a code runs past four symbols
  localparam logic [2:0] SYM_MAX_LEN  = 3'd4;
  localparam logic [2:0] SYM_OVERLONG = 3'd5;

  // Output character codes
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_UNKNOWN = 8'h3F;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;

  // Register reset values
  localparam logic [REG_BITS-1:0] DASH_THRESHOLD_RST = 16'd300;
  localparam logic [REG_BITS-1:0] LETTER_GAP_RST     = 16'd1000;
  localparam logic [REG_BITS-1:0] WORD_GAP_RST       = 16'd3000;

  // Result queue depth; a tick request is taken only with room for two results
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Register indexes on the configuration channel
  typedef enum logic [1:0] {
    CFG_DASH_THRESHOLD = 2'd0,
    CFG_LETTER_GAP     = 2'd1,
    CFG_WORD_GAP       = 2'd2
  } mkd_cfg_idx_t;

  typedef struct packed {
    logic [REG_BITS-1:0] dash_threshold;
    logic [REG_BITS-1:0] letter_gap;
    logic [REG_BITS-1:0] word_gap;
  } mkd_cfg_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last_of_run;
  } mkd_result_t;

  // Results produced by one tick: none, one letter, or CR then LF
  typedef struct packed {
    logic [1:0]  count;
    mkd_result_t first;
    mkd_result_t second;
  } mkd_push_t;

  // Letter table A to Z: code length and pattern (bit i is symbol i, 1 = dash)
  localparam logic [2:0] CODE_LEN [26] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };
  localparam logic [3:0] CODE_BITS [26] = '{
    4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14, 4'd5, 4'd2, 4'd3,
    4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1, 4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3
  };

  // Match a symbol code against the table; '?' when nothing matches
  function automatic logic [7:0] lookup_letter(input logic [2:0] count,
                                               input logic [3:0] pattern);
    logic [7:0] ch;
    ch = CH_UNKNOWN;
    for (int i = 0; i < 26; i++) begin
      if (CODE_LEN[i] == count && CODE_BITS[i] == pattern) begin
        ch = CH_A + 8'(i);
      end
    end
    return ch;
  endfunction

endpackage

/* rtl/core/mkd_channels.sv */
// Channel interfaces of the morse key decoder: tick input, character output
// and register writes. Depends on mkd_pkg for the field widths.
interface mkd_in_if;
  logic valid;
  logic ready;
  logic key_down;

  modport source (output valid, output key_down, input ready);
  modport sink   (input valid, input key_down, output ready);
endinterface

interface mkd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last_of_run;

  modport source (output valid, output character, output last_of_run, input ready);
  modport sink   (input valid, input character, input last_of_run, output ready);
endinterface

interface mkd_cfg_if import mkd_pkg::*;;
  logic                valid;
  logic                ready;
  logic [1:0]          index;
  logic [REG_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/morse_key_decoder.sv */
// Top level of the morse key decoder: register block, tick engine and result
// queue. Depends on mkd_pkg, mkd_channels and the three submodules.
//
// One key sample (one tick) is taken per clock cycle, and its state update is
// done in that same cycle; letters leave as single characters with
// last_of_run set, and a word end leaves as CR then LF, LF marked last.
// Results wait in a four-entry queue; in_chan.ready is high
// while the queue has two free slots, so ticks flow every cycle unless the
// character sink stalls and the queue fills. Register writes are always
// taken (cfg_chan.ready tied high) and should only be made while no tick is
// in flight; an index past word_gap is ignored.
module morse_key_decoder import mkd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  mkd_in_if.sink    in_chan,
  mkd_out_if.source out_chan,
  mkd_cfg_if.sink   cfg_chan
);

  mkd_cfg_t    cfg;
  mkd_push_t   push;
  mkd_result_t head;
  logic        room;
  logic        tick_accept;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = room;
  assign tick_accept    = in_chan.valid && room;

  mkd_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_chan.valid),
    .wr_index (cfg_chan.index),
    .wr_data  (cfg_chan.data),
    .cfg      (cfg)
  );

  mkd_tick_engine u_tick_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (tick_accept),
    .key_down (in_chan.key_down),
    .cfg      (cfg),
    .push     (push)
  );

  mkd_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (head)
  );

  assign out_chan.character   = head.character;
  assign out_chan.last_of_run = head.last_of_run;

endmodule

/* rtl/core/mkd_cfg_regs.sv */
// Timing registers of the morse key decoder, written over the configuration
// channel. Depends on mkd_pkg.
module mkd_cfg_regs import mkd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [1:0]          wr_index,
  input  logic [REG_BITS-1:0] wr_data,
  output mkd_cfg_t            cfg
);

  mkd_cfg_t cfg_r, cfg_nxt;

  // Decode the register index; an index past the list drops the request
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (mkd_cfg_idx_t'(wr_index))
        CFG_DASH_THRESHOLD: cfg_nxt.dash_threshold = wr_data;
        CFG_LETTER_GAP:     cfg_nxt.letter_gap     = wr_data;
        CFG_WORD_GAP:       cfg_nxt.word_gap       = wr_data;
        default:            cfg_nxt                = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dash_threshold <= DASH_THRESHOLD_RST;
      cfg_r.letter_gap     <= LETTER_GAP_RST;
      cfg_r.word_gap       <= WORD_GAP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/mkd_tick_engine.sv */
// Per-tick key timing, symbol collection and letter/word closing of the morse
// key decoder. Depends on mkd_pkg.
module mkd_tick_engine import mkd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  logic      key_down,
  input  mkd_cfg_t  cfg,
  output mkd_push_t push
);

  logic                  key_held_r, key_held_nxt;
  logic [TIMER_BITS-1:0] hold_ticks_r, hold_ticks_nxt;
  logic [TIMER_BITS-1:0] idle_ticks_r, idle_ticks_nxt;
  logic [2:0]            symbol_count_r, symbol_count_nxt;
  logic [3:0]            symbol_pattern_r, symbol_pattern_nxt;
  logic                  letters_pending_r, letters_pending_nxt;

  logic [TIMER_BITS-1:0] idle_inc;
  logic                  is_dash;
  logic                  word_end_held;
  logic                  word_end_inc;
  logic                  letter_end;
  mkd_push_t             word_push;

  // Saturating idle count and the threshold compares
  always_comb begin
    idle_inc      = (idle_ticks_r == TIMER_MAX) ? idle_ticks_r : idle_ticks_r + 1'b1;
    is_dash       = CMP_BITS'(hold_ticks_r) >= CMP_BITS'(cfg.dash_threshold);
    word_end_held = letters_pending_r && (CMP_BITS'(idle_ticks_r) > CMP_BITS'(cfg.word_gap));
    word_end_inc  = letters_pending_r && (CMP_BITS'(idle_inc) > CMP_BITS'(cfg.word_gap));
    letter_end    = (symbol_count_r != 3'd0) &&
                    (CMP_BITS'(idle_inc) > CMP_BITS'(cfg.letter_gap));
    word_push.count              = 2'd2;
    word_push.first.character    = CH_CR;
    word_push.first.last_of_run  = 1'b0;
    word_push.second.character   = CH_LF;
    word_push.second.last_of_run = 1'b1;
  end

  // Advance the key state for one tick request
  always_comb begin
    key_held_nxt        = key_held_r;
    hold_ticks_nxt      = hold_ticks_r;
    idle_ticks_nxt      = idle_ticks_r;
    symbol_count_nxt    = symbol_count_r;
    symbol_pattern_nxt  = symbol_pattern_r;
    letters_pending_nxt = letters_pending_r;
    push                = '0;
    if (accept) begin
      if (key_down) begin
        if (key_held_r) begin
          // still pressed: extend the hold
          if (hold_ticks_r != TIMER_MAX) begin
            hold_ticks_nxt = hold_ticks_r + 1'b1;
          end
        end else begin
          // press starts: close a word on the idle count from before the press
          key_held_nxt   = 1'b1;
          hold_ticks_nxt = TIMER_BITS'(1);
          if (word_end_held) begin
            push                = word_push;
            letters_pending_nxt = 1'b0;
          end
        end
      end else if (key_held_r) begin
        // release: record a dot or a dash, or mark the code overlong
        key_held_nxt = 1'b0;
        if (symbol_count_r < SYM_MAX_LEN) begin
          if (is_dash) begin
            symbol_pattern_nxt = symbol_pattern_r | (4'b0001 << symbol_count_r[1:0]);
          end
          symbol_count_nxt = symbol_count_r + 3'd1;
        end else begin
          symbol_count_nxt = SYM_OVERLONG;
        end
        hold_ticks_nxt = '0;
        idle_ticks_nxt = '0;
      end else begin
        // key up: letter end takes priority over word end
        idle_ticks_nxt = idle_inc;
        if (letter_end) begin
          push.count                = 2'd1;
          push.first.character      = lookup_letter(symbol_count_r, symbol_pattern_r);
          push.first.last_of_run    = 1'b1;
          symbol_count_nxt          = '0;
          symbol_pattern_nxt        = '0;
          letters_pending_nxt       = 1'b1;
        end else if (word_end_inc) begin
          push                = word_push;
          letters_pending_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_held_r        <= 1'b0;
      hold_ticks_r      <= '0;
      idle_ticks_r      <= '0;
      symbol_count_r    <= '0;
      symbol_pattern_r  <= '0;
      letters_pending_r <= 1'b0;
    end else begin
      key_held_r        <= key_held_nxt;
      hold_ticks_r      <= hold_ticks_nxt;
      idle_ticks_r      <= idle_ticks_nxt;
      symbol_count_r    <= symbol_count_nxt;
      symbol_pattern_r  <= symbol_pattern_nxt;
      letters_pending_r <= letters_pending_nxt;
    end
  end

endmodule

/* rtl/core/mkd_out_queue.sv */
// Small result queue of the morse key decoder: takes up to two results per
// cycle and hands out one per cycle while the sink is ready. Depends on mkd_pkg.
module mkd_out_queue import mkd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  mkd_push_t   push,
  output logic        room,
  output logic        out_valid,
  input  logic        out_ready,
  output mkd_result_t out_data
);

  mkd_result_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] count_r, count_nxt;
  logic [QPTR_BITS-1:0] wr_ptr_second;
  logic                 pop;

  // Pointer and fill bookkeeping
  always_comb begin
    pop           = out_valid && out_ready;
    wr_ptr_second = wr_ptr_r + 1'b1;
    wr_ptr_nxt    = wr_ptr_r + QPTR_BITS'(push.count);
    rd_ptr_nxt    = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt     = count_r + QCNT_BITS'(push.count) - QCNT_BITS'(pop);
  end

  // Store the pushed results
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slot_r[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      slot_r[wr_ptr_second] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold back new ticks unless two free slots remain
  assign room      = count_r <= QCNT_BITS'(QUEUE_DEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_data  = slot_r[rd_ptr_r];

endmodule

/* rtl/core/mkd_checker.sv */
// Port-level checks of the morse key decoder, bound to the top level.
// Depends on mkd_pkg and morse_key_decoder_macros.svh.
`include "morse_key_decoder_macros.svh"

module mkd_checker import mkd_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] character,
  input logic       last_of_run
);

  logic stalled;
  logic cr_taken;

  // Output stall and CR handshake seen on the ports
  assign stalled  = out_valid && !out_ready;
  assign cr_taken = out_valid && out_ready && (character == CH_CR);

  // A stalled character holds
  `MKD_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable({character, last_of_run}))

  // Only CR goes out without the last mark
  `MKD_ASSERT_NOW(a_last_mark, out_valid, last_of_run == (character != CH_CR))

  // CR is followed at once by its LF
  `MKD_ASSERT_NEXT(a_cr_then_lf, cr_taken, out_valid && character == CH_LF)

  // Nothing waits to go out after reset
  `MKD_ASSERT_RESET(a_reset_empty, !out_valid)

endmodule

bind morse_key_decoder mkd_checker u_mkd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .character   (out_chan.character),
  .last_of_run (out_chan.last_of_run)
);
